/* hw/rtl/rbst_pkg.sv */
// ----------------------------------------------------------------------------
// rbst_pkg
// Shared constants and types for the ray versus box slab test pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

package rbst_pkg;

   localparam int CoordW       = 32;
   localparam int DirW         = 16;
   localparam int NumW         = CoordW + 1;
   localparam int FracShift    = 14;
   localparam int DvdW         = 48;
   localparam int BitsPerStage = 4;
   localparam int DivStages    = DvdW / BitsPerStage;
   localparam int TW           = 48;
   localparam int Axes         = 3;

   localparam logic signed [TW-1:0] TMin = {1'b1, {(TW-1){1'b0}}};
   localparam logic signed [TW-1:0] TMax = {1'b0, {(TW-1){1'b1}}};

   typedef logic signed [CoordW-1:0] coord_type;
   typedef logic signed [DirW-1:0]   dir_type;
   typedef logic signed [TW-1:0]     tpar_type;

   typedef struct packed {
      logic low_neg;
      logic high_neg;
      logic dir_neg;
      logic dir_zero;
      logic in_slab;
   } axis_side_type;

endpackage

`default_nettype wire

/* hw/rtl/rbst_if.sv */
// ----------------------------------------------------------------------------
// rbst_req_if / rbst_rsp_if
// Valid-ready channels for ray-box requests and hit results.
// ----------------------------------------------------------------------------
`default_nettype none

interface rbst_req_if;
   logic                valid;
   logic                ready;
   logic signed [31:0]  origin_x;
   logic signed [31:0]  origin_y;
   logic signed [31:0]  origin_z;
   logic signed [15:0]  direction_x;
   logic signed [15:0]  direction_y;
   logic signed [15:0]  direction_z;
   logic signed [31:0]  box_low_x;
   logic signed [31:0]  box_low_y;
   logic signed [31:0]  box_low_z;
   logic signed [31:0]  box_high_x;
   logic signed [31:0]  box_high_y;
   logic signed [31:0]  box_high_z;

   modport source (output valid, origin_x, origin_y, origin_z, direction_x, direction_y,
                   direction_z, box_low_x, box_low_y, box_low_z, box_high_x, box_high_y,
                   box_high_z, input ready);
   modport sink (input valid, origin_x, origin_y, origin_z, direction_x, direction_y,
                 direction_z, box_low_x, box_low_y, box_low_z, box_high_x, box_high_y,
                 box_high_z, output ready);
endinterface

interface rbst_rsp_if;
   logic valid;
   logic ready;
   logic hit;

   modport source (output valid, hit, input ready);
   modport sink (input valid, hit, output ready);
endinterface

`default_nettype wire

/* hw/rtl/rbst_div.sv */
// ----------------------------------------------------------------------------
// rbst_div
// Pipelined unsigned restoring divider, four quotient bits per stage.
// ----------------------------------------------------------------------------
`default_nettype none

module rbst_div (
   input  wire logic                      clock,
   input  wire logic                      en,
   input  wire logic [rbst_pkg::DvdW-1:0] dvd_in,
   input  wire logic [rbst_pkg::DirW-1:0] dsr_in,
   output logic      [rbst_pkg::DvdW-1:0] quo_out
);
   import rbst_pkg::*;

   logic [DvdW-1:0] dvd_ff [DivStages];
   logic [DvdW-1:0] quo_ff [DivStages];
   logic [DirW-1:0] rem_ff [DivStages];
   logic [DirW-1:0] dsr_ff [DivStages];

   for (genvar g = 0; g < DivStages; g++) begin : g_stage
      logic [DvdW-1:0] dvd_src;
      logic [DvdW-1:0] quo_src;
      logic [DirW-1:0] rem_src;
      logic [DirW-1:0] dsr_src;
      logic [DvdW-1:0] dvd_in_s;
      logic [DvdW-1:0] quo_in_s;
      logic [DirW-1:0] rem_in_s;
      logic [DirW-1:0] dsr_s;

      if (g == 0) begin : g_head
         assign dvd_src = dvd_in;
         assign quo_src = '0;
         assign rem_src = '0;
         assign dsr_src = dsr_in;
      end else begin : g_body
         assign dvd_src = dvd_ff[g-1];
         assign quo_src = quo_ff[g-1];
         assign rem_src = rem_ff[g-1];
         assign dsr_src = dsr_ff[g-1];
      end

      always_comb begin
         logic [DirW:0] trial;
         dvd_in_s = dvd_src;
         quo_in_s = quo_src;
         rem_in_s = rem_src;
         dsr_s    = dsr_src;
         for (int k = 0; k < BitsPerStage; k++) begin
            trial    = {rem_in_s, dvd_in_s[DvdW-1]};
            dvd_in_s = {dvd_in_s[DvdW-2:0], 1'b0};
            if (trial >= {1'b0, dsr_s}) begin
               trial    = trial - {1'b0, dsr_s};
               quo_in_s = {quo_in_s[DvdW-2:0], 1'b1};
            end else begin
               quo_in_s = {quo_in_s[DvdW-2:0], 1'b0};
            end
            rem_in_s = trial[DirW-1:0];
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            dvd_ff[g] <= dvd_in_s;
            quo_ff[g] <= quo_in_s;
            rem_ff[g] <= rem_in_s;
            dsr_ff[g] <= dsr_s;
         end
      end
   end

   assign quo_out = quo_ff[DivStages-1];

endmodule

`default_nettype wire

/* hw/rtl/ray_box_slab_test.sv */
// Each request passes the input, divider, slab, entry/exit and hit registers in turn.
// One request per cycle unless stalled; twelve four-bit divider stages set the depth.
// The whole pipeline advances together whenever the output register is free or taken.
// Reset is synchronous and active high; it clears the valid bits only.
// ----------------------------------------------------------------------------
// ray_box_slab_test
// Slab test of a ray against an axis-aligned box, fully pipelined.
// ----------------------------------------------------------------------------
`default_nettype none

module ray_box_slab_test (
   input wire logic    clock,
   input wire logic    reset,
   rbst_req_if.sink    req,
   rbst_rsp_if.source  rsp
);
   import rbst_pkg::*;

   logic adv;

   logic      in_vld_ff;
   coord_type o_ff  [Axes];
   dir_type   d_ff  [Axes];
   coord_type lo_ff [Axes];
   coord_type hi_ff [Axes];

   logic          div_vld_ff  [DivStages];
   axis_side_type side_ff     [Axes][DivStages];
   logic [DvdW-1:0] quo_lo [Axes];
   logic [DvdW-1:0] quo_hi [Axes];

   logic     t_vld_ff;
   tpar_type t0_ff [Axes];
   tpar_type t1_ff [Axes];
   logic     ok_ff [Axes];

   logic     m_vld_ff;
   tpar_type entry_ff;
   tpar_type exit_ff;
   logic     m_ok_ff;

   logic out_vld_ff;
   logic hit_ff;

   assign adv       = !out_vld_ff || rsp.ready;
   assign req.ready = adv;
   assign rsp.valid = out_vld_ff;
   assign rsp.hit   = hit_ff;

   always_ff @(posedge clock) begin
      if (adv) begin
         o_ff[0]  <= req.origin_x;
         o_ff[1]  <= req.origin_y;
         o_ff[2]  <= req.origin_z;
         d_ff[0]  <= req.direction_x;
         d_ff[1]  <= req.direction_y;
         d_ff[2]  <= req.direction_z;
         lo_ff[0] <= req.box_low_x;
         lo_ff[1] <= req.box_low_y;
         lo_ff[2] <= req.box_low_z;
         hi_ff[0] <= req.box_high_x;
         hi_ff[1] <= req.box_high_y;
         hi_ff[2] <= req.box_high_z;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff  <= 1'b0;
         t_vld_ff   <= 1'b0;
         m_vld_ff   <= 1'b0;
         out_vld_ff <= 1'b0;
         for (int s = 0; s < DivStages; s++) begin
            div_vld_ff[s] <= 1'b0;
         end
      end else if (adv) begin
         in_vld_ff     <= req.valid;
         div_vld_ff[0] <= in_vld_ff;
         for (int s = 1; s < DivStages; s++) begin
            div_vld_ff[s] <= div_vld_ff[s-1];
         end
         t_vld_ff   <= div_vld_ff[DivStages-1];
         m_vld_ff   <= t_vld_ff;
         out_vld_ff <= m_vld_ff;
      end
   end

   for (genvar a = 0; a < Axes; a++) begin : g_axis
      logic signed [NumW-1:0] num_lo;
      logic signed [NumW-1:0] num_hi;
      logic [NumW-1:0]        mag_lo;
      logic [NumW-1:0]        mag_hi;
      logic [DirW-1:0]        dmag;
      axis_side_type          side_in;
      tpar_type               q_lo;
      tpar_type               q_hi;
      axis_side_type          side_out;

      always_comb begin
         num_lo = {lo_ff[a][CoordW-1], lo_ff[a]} - {o_ff[a][CoordW-1], o_ff[a]};
         num_hi = {hi_ff[a][CoordW-1], hi_ff[a]} - {o_ff[a][CoordW-1], o_ff[a]};
         mag_lo = num_lo[NumW-1] ? NumW'(-num_lo) : NumW'(num_lo);
         mag_hi = num_hi[NumW-1] ? NumW'(-num_hi) : NumW'(num_hi);
         dmag   = d_ff[a][DirW-1] ? DirW'(-d_ff[a]) : DirW'(d_ff[a]);
         side_in.low_neg  = num_lo[NumW-1];
         side_in.high_neg = num_hi[NumW-1];
         side_in.dir_neg  = d_ff[a][DirW-1];
         side_in.dir_zero = (d_ff[a] == '0);
         side_in.in_slab  = (lo_ff[a] <= o_ff[a]) && (o_ff[a] <= hi_ff[a]);
      end

      rbst_div u_div_lo (
         .clock   (clock),
         .en      (adv),
         .dvd_in  ({{(DvdW-NumW-FracShift){1'b0}}, mag_lo, {FracShift{1'b0}}}),
         .dsr_in  (dmag),
         .quo_out (quo_lo[a])
      );

      rbst_div u_div_hi (
         .clock   (clock),
         .en      (adv),
         .dvd_in  ({{(DvdW-NumW-FracShift){1'b0}}, mag_hi, {FracShift{1'b0}}}),
         .dsr_in  (dmag),
         .quo_out (quo_hi[a])
      );

      always_ff @(posedge clock) begin
         if (adv) begin
            side_ff[a][0] <= side_in;
            for (int s = 1; s < DivStages; s++) begin
               side_ff[a][s] <= side_ff[a][s-1];
            end
         end
      end

      always_comb begin
         side_out = side_ff[a][DivStages-1];
         q_lo = (side_out.low_neg ^ side_out.dir_neg) ? TW'(-quo_lo[a]) : TW'(quo_lo[a]);
         q_hi = (side_out.high_neg ^ side_out.dir_neg) ? TW'(-quo_hi[a]) : TW'(quo_hi[a]);
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            if (side_out.dir_zero) begin
               t0_ff[a] <= TMin;
               t1_ff[a] <= TMax;
            end else if (side_out.dir_neg) begin
               t0_ff[a] <= q_hi;
               t1_ff[a] <= q_lo;
            end else begin
               t0_ff[a] <= q_lo;
               t1_ff[a] <= q_hi;
            end
            ok_ff[a] <= !side_out.dir_zero || side_out.in_slab;
         end
      end
   end

   always_ff @(posedge clock) begin
      tpar_type e_in;
      tpar_type x_in;
      e_in = (t0_ff[0] > t0_ff[1]) ? t0_ff[0] : t0_ff[1];
      e_in = (t0_ff[2] > e_in) ? t0_ff[2] : e_in;
      x_in = (t1_ff[0] < t1_ff[1]) ? t1_ff[0] : t1_ff[1];
      x_in = (t1_ff[2] < x_in) ? t1_ff[2] : x_in;
      if (adv) begin
         entry_ff <= e_in;
         exit_ff  <= x_in;
         m_ok_ff  <= ok_ff[0] && ok_ff[1] && ok_ff[2];
         hit_ff   <= m_ok_ff && (entry_ff <= exit_ff);
      end
   end

endmodule

`default_nettype wire
